// ===== design/kmsd_pkg.sv =====
package kmsd_pkg;

  localparam int ROWS_DEF   = 8;
  localparam int COLS_DEF   = 8;
  localparam int LEVEL_W    = 8;
  localparam int ROW_W      = 3;
  localparam int KEY_W      = 64;
  localparam int KEY_POS_W  = $clog2(KEY_W);
  localparam int CNT_W      = 4;
  localparam int FILTER_W   = 8;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_ENABLE   = 3'd0,
    REG_ROW_COUNT     = 3'd1,
    REG_COL_COUNT     = 3'd2,
    REG_FILTER_COUNT  = 3'd3,
    REG_SCAN_INTERVAL = 3'd4
  } kmsd_reg_t;

  typedef enum logic {
    PH_START  = 1'b0,
    PH_SAMPLE = 1'b1
  } kmsd_phase_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic multi;
    logic last;
  } kmsd_ctl_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v > maxv) r = maxv;
    if (r == '0) r = CNT_W'(1);
    return r;
  endfunction

endpackage

// ===== design/kmsd_seq.sv =====
module kmsd_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [kmsd_pkg::CNT_W-1:0]       rows,
  input  logic [kmsd_pkg::FILTER_W-1:0]    filt_len,
  input  logic [kmsd_pkg::INTERVAL_W-1:0]  scan_interval,
  output kmsd_pkg::kmsd_ctl_t              ctl,
  output logic [kmsd_pkg::ROW_W-1:0]       scan_row
);
  import kmsd_pkg::*;

  kmsd_phase_t             phase, phase_next;
  logic [FILTER_W-1:0]     sample_count;
  logic [INTERVAL_W-1:0]   elapsed_ticks;
  logic [INTERVAL_W-1:0]   elapsed_inc;
  logic [FILTER_W-1:0]     sample_inc;
  logic [CNT_W-1:0]        row_inc;

  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign sample_inc  = sample_count + 1'b1;
  assign row_inc     = CNT_W'(scan_row) + 1'b1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_START:  if (advance) phase_next = PH_SAMPLE;
      PH_SAMPLE: if (ctl.sample && ctl.last) phase_next = PH_START;
      default:   phase_next = PH_START;
    endcase
  end

  always_comb begin
    ctl.clear  = advance && (phase == PH_START);
    ctl.sample = advance && (phase == PH_SAMPLE) && (elapsed_inc >= scan_interval);
    ctl.multi  = sample_inc > FILTER_W'(1);
    ctl.last   = sample_inc >= filt_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      scan_row      <= '0;
      sample_count  <= '0;
      elapsed_ticks <= '0;
    end else begin
      phase <= phase_next;
      if (ctl.clear) begin
        sample_count  <= '0;
        elapsed_ticks <= '0;
      end else if (ctl.sample) begin
        sample_count  <= sample_inc;
        elapsed_ticks <= '0;
        if (ctl.last) scan_row <= (row_inc >= rows) ? '0 : row_inc[ROW_W-1:0];
      end else if (advance) begin
        elapsed_ticks <= elapsed_inc;
      end
    end
  end

endmodule

// ===== design/kmsd_lane.sv =====
module kmsd_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  kmsd_pkg::kmsd_ctl_t            ctl,
  input  logic                           lane_en,
  input  logic                           level,
  input  logic [kmsd_pkg::FILTER_W-1:0]  filt_len,
  output logic                           upd,
  output logic                           pressed
);
  import kmsd_pkg::*;

  logic [FILTER_W-1:0] stable_count;
  logic [FILTER_W-1:0] cnt_new;
  logic                prev_pressed;

  assign pressed = ~level;
  assign cnt_new = (ctl.multi && (prev_pressed != pressed)) ? '0 : stable_count + 1'b1;
  assign upd     = ctl.sample && lane_en && ctl.last && (cnt_new == filt_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count <= '0;
      prev_pressed <= 1'b0;
    end else if (ctl.clear) begin
      stable_count <= '0;
    end else if (ctl.sample) begin
      prev_pressed <= lane_en && pressed;
      if (lane_en) stable_count <= cnt_new;
    end
  end

endmodule

// ===== design/kmsd_merge.sv =====
module kmsd_merge #(
  parameter int MAX_COLS = kmsd_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [MAX_COLS-1:0]           upd,
  input  logic [MAX_COLS-1:0]           pressed,
  input  logic [kmsd_pkg::ROW_W-1:0]    scan_row,
  input  logic [kmsd_pkg::CNT_W-1:0]    cols,
  output logic [kmsd_pkg::KEY_W-1:0]    key_map
);
  import kmsd_pkg::*;

  localparam int BASE_W = ROW_W + CNT_W;

  logic [BASE_W-1:0] base;
  logic [KEY_W-1:0]  key_map_next;
  logic [BASE_W-1:0] pos;

  assign base = BASE_W'(scan_row) * BASE_W'(cols);

  always_comb begin
    key_map_next = key_map;
    pos          = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      pos = base + BASE_W'(i);
      if (upd[i]) key_map_next[pos[KEY_POS_W-1:0]] = pressed[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) key_map <= '0;
    else     key_map <= key_map_next;
  end

endmodule

// ===== design/key_matrix_scan_debounce.sv =====
// key matrix scanner with debounce
// in channel: one beat per scan tick, carrying col_levels (bit i = column i,
//   low = pressed), taken when in_valid is high and in_stall is low
// out channel: one beat per input beat, in order, in the cycle after the input
//   beat is taken: drive_row (row driven during that tick), row_active,
//   key_map (debounced map, bit col + row * cols set when pressed), row_done
// throughput: one tick per cycle unless stalled; each column has a counter
//   lane; a merge stage writes the finished row to key_map in the same cycle
// the output register holds a finished beat while out_stall is high; in_stall
//   is raised then, so no tick is lost or duplicated
// config: cfg_write with cfg_index / cfg_data writes one register, only when
//   no beat is in flight (a user rule the block does not enforce); scan_enable
//   low makes every tick a no-op that still returns a beat with row_active low
// reset: scanning disabled, 1 row, 1 column, filter 4, interval 10, key map
//   cleared, scan starts at row 0
module key_matrix_scan_debounce #(
  parameter int MAX_ROWS = kmsd_pkg::ROWS_DEF,
  parameter int MAX_COLS = kmsd_pkg::COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kmsd_pkg::LEVEL_W-1:0]      col_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kmsd_pkg::ROW_W-1:0]        drive_row,
  output logic                              row_active,
  output logic [kmsd_pkg::KEY_W-1:0]        key_map,
  output logic                              row_done
);
  import kmsd_pkg::*;

  logic                  scan_enable;
  logic [CNT_W-1:0]      row_count;
  logic [CNT_W-1:0]      col_count;
  logic [FILTER_W-1:0]   filt_len;
  logic [INTERVAL_W-1:0] scan_interval;
  logic [CNT_W-1:0]      rows;
  logic [CNT_W-1:0]      cols;
  logic                  accept;
  logic                  advance;
  kmsd_ctl_t             ctl;
  logic [ROW_W-1:0]      scan_row;
  logic [MAX_COLS-1:0]   upd;
  logic [MAX_COLS-1:0]   pressed;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable   <= 1'b0;
      row_count     <= CNT_W'(1);
      col_count     <= CNT_W'(1);
      filt_len      <= FILTER_W'(4);
      scan_interval <= INTERVAL_W'(10);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCAN_ENABLE:   scan_enable   <= cfg_data[0];
        REG_ROW_COUNT:     row_count     <= cfg_data[CNT_W-1:0];
        REG_COL_COUNT:     col_count     <= cfg_data[CNT_W-1:0];
        REG_FILTER_COUNT:  filt_len      <= cfg_data[FILTER_W-1:0];
        REG_SCAN_INTERVAL: scan_interval <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows     = clamp_cnt(row_count, CNT_W'(MAX_ROWS));
  assign cols     = clamp_cnt(col_count, CNT_W'(MAX_COLS));
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign advance  = accept && scan_enable;

  kmsd_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rows          (rows),
    .filt_len      (filt_len),
    .scan_interval (scan_interval),
    .ctl           (ctl),
    .scan_row      (scan_row)
  );

  for (genvar g = 0; g < MAX_COLS; g++) begin : g_lane
    kmsd_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .lane_en      (CNT_W'(g) < cols),
      .level        (col_levels[g]),
      .filt_len     (filt_len),
      .upd          (upd[g]),
      .pressed      (pressed[g])
    );
  end

  // key map register is the output map; it only moves on an accepted beat
  kmsd_merge #(
    .MAX_COLS (MAX_COLS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .pressed  (pressed),
    .scan_row (scan_row),
    .cols     (cols),
    .key_map  (key_map)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_row  <= scan_row;
      row_active <= scan_enable;
      row_done   <= ctl.sample && ctl.last;
    end
  end

endmodule

// ===== verif/tb_key_matrix_scan_debounce.sv =====
`timescale 1ns / 1ps

module tb_key_matrix_scan_debounce;
  import kmsd_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             active;
    logic [KEY_W-1:0] keys;
    logic             done;
  } scan_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    col_levels;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROW_W-1:0]      drive_row;
  logic                  row_active;
  logic [KEY_W-1:0]      key_map;
  logic                  row_done;

  key_matrix_scan_debounce i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .col_levels (col_levels),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive_row  (drive_row),
    .row_active (row_active),
    .key_map    (key_map),
    .row_done   (row_done)
  );

  // scanner copy: registers
  logic                  en_reg;
  logic [CNT_W-1:0]      rows_reg;
  logic [CNT_W-1:0]      cols_reg;
  logic [FILTER_W-1:0]   filter_reg;
  logic [INTERVAL_W-1:0] interval_reg;
  // scanner copy: state
  kmsd_phase_t           ph;
  logic [ROW_W-1:0]      cur_row;
  logic [FILTER_W-1:0]   samples;
  logic [INTERVAL_W-1:0] elapsed;
  logic [LEVEL_W-1:0]    prev_pressed;
  logic [7:0]            stable_cnt [COLS_DEF];
  logic [KEY_W-1:0]      keys;

  scan_beat_t         pending_scans[$];
  int unsigned        mismatch_count = 0;
  bit                 idle_on = 1'b1;
  logic [LEVEL_W-1:0] held_levels;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("tb_key_matrix_scan_debounce: done, errors");
    $finish;
  end

  task automatic reset_scan_model();
    en_reg       = 1'b0;
    rows_reg     = CNT_W'(1);
    cols_reg     = CNT_W'(1);
    filter_reg   = FILTER_W'(4);
    interval_reg = INTERVAL_W'(10);
    ph           = PH_START;
    cur_row      = '0;
    samples      = '0;
    elapsed      = '0;
    prev_pressed = '0;
    keys         = '0;
    for (int i = 0; i < COLS_DEF; i++) stable_cnt[i] = '0;
  endtask

  function automatic scan_beat_t predict_scan_tick(input logic [LEVEL_W-1:0] lev);
    scan_beat_t         r;
    int                 rows;
    int                 cols;
    int                 pos;
    logic [LEVEL_W-1:0] pressed;
    logic               row_end;
    r.row    = cur_row;
    r.active = en_reg;
    r.done   = 1'b0;
    rows = (rows_reg > ROWS_DEF) ? ROWS_DEF : ((rows_reg == 0) ? 1 : int'(rows_reg));
    cols = (cols_reg > COLS_DEF) ? COLS_DEF : ((cols_reg == 0) ? 1 : int'(cols_reg));
    if (en_reg) begin
      if (ph == PH_START) begin
        for (int i = 0; i < COLS_DEF; i++) stable_cnt[i] = '0;
        elapsed = '0;
        samples = '0;
        ph      = PH_SAMPLE;
      end else begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (elapsed >= interval_reg) begin
          pressed = ~lev & LEVEL_W'((1 << cols) - 1);
          samples = samples + 1'b1;
          row_end = (samples >= filter_reg);
          for (int i = 0; i < cols; i++) begin
            stable_cnt[i] = stable_cnt[i] + 1'b1;
            if (samples > 1 && prev_pressed[i] != pressed[i]) stable_cnt[i] = '0;
            if (row_end && stable_cnt[i] == filter_reg) begin
              pos = (i + int'(cur_row) * cols) % KEY_W;
              keys[pos] = pressed[i];
            end
          end
          prev_pressed = pressed;
          elapsed      = '0;
          if (row_end) begin
            cur_row = (int'(cur_row) + 1 >= rows) ? '0 : cur_row + 1'b1;
            ph      = PH_START;
            r.done  = 1'b1;
          end
        end
      end
    end
    r.keys = keys;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_beats
    scan_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scans.size() == 0) begin
        report_mismatch("output beat with nothing pending");
      end else begin
        want = pending_scans.pop_front();
        if (drive_row !== want.row)
          report_mismatch($sformatf("drive_row got %0d want %0d", drive_row, want.row));
        if (row_active !== want.active)
          report_mismatch($sformatf("row_active got %b want %b", row_active, want.active));
        if (key_map !== want.keys)
          report_mismatch($sformatf("key_map got %h want %h", key_map, want.keys));
        if (row_done !== want.done)
          report_mismatch($sformatf("row_done got %b want %b", row_done, want.done));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (!rst && idle_on) ? ($urandom_range(99) < 20) : 1'b0;
  end

  task automatic send_tick(input logic [LEVEL_W-1:0] lev);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    col_levels <= lev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_scans.push_back(predict_scan_tick(lev));
    @(negedge clk);
  endtask

  task automatic drain_beats();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input kmsd_reg_t idx, input int unsigned val);
    drain_beats();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SCAN_ENABLE:   en_reg = val[0];
      REG_ROW_COUNT:     rows_reg = CNT_W'(val);
      REG_COL_COUNT:     cols_reg = CNT_W'(val);
      REG_FILTER_COUNT:  filter_reg = FILTER_W'(val);
      REG_SCAN_INTERVAL: interval_reg = INTERVAL_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_scan(input int unsigned en, input int unsigned rows, input int unsigned cols,
                          input int unsigned filt, input int unsigned intv);
    write_reg(REG_SCAN_ENABLE, en);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_FILTER_COUNT, filt);
    write_reg(REG_SCAN_INTERVAL, intv);
  endtask

  // stable key pattern with occasional changes and single-tick contact bounce, or fully random levels at noise_pct 100
  function automatic logic [LEVEL_W-1:0] next_levels(input int change_pct, input int noise_pct);
    if (noise_pct >= 100) return LEVEL_W'($urandom);
    if ($urandom_range(99) < change_pct) held_levels = LEVEL_W'($urandom);
    if ($urandom_range(99) < noise_pct)
      return held_levels ^ (LEVEL_W'(1) << $urandom_range(LEVEL_W - 1));
    return held_levels;
  endfunction

  task automatic test_disabled();
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h5A);
  endtask

  task automatic test_full_rows();
    set_scan(1, 2, 8, 1, 0);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h55);
    send_tick(8'hFF);
    send_tick(8'hAA);
  endtask

  task automatic test_filter_zero();
    set_scan(1, 1, 8, 0, 1);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h0F);
  endtask

  task automatic test_count_clamp();
    set_scan(1, 0, 0, 1, 0);
    send_tick(8'h00);
    send_tick(8'hFE);
    set_scan(1, 15, 15, 1, 0);
    send_tick(8'h00);
    send_tick(8'h3C);
    send_tick(8'h00);
    send_tick(8'h81);
  endtask

  task automatic test_bounce();
    set_scan(1, 1, 8, 3, 1);
    send_tick(8'hFF);
    send_tick(8'hF0);
    send_tick(8'hF1);
    send_tick(8'hF0);
    write_reg(REG_SCAN_ENABLE, 0);
    send_tick(8'h00);
    send_tick(8'h00);
  endtask

  task automatic test_interval_max();
    set_scan(1, 2, 8, 1, 16'hFFFF);
    held_levels = 8'h69;
    repeat (60) send_tick(next_levels(0, 0));
  endtask

  task automatic test_random_scan();
    int noise;
    for (int p = 0; p < 8; p++) begin
      idle_on = (p != 3);
      noise   = (p == 6) ? 100 : $urandom_range(0, 10);
      if (p == 7) begin
        set_scan(1, $urandom_range(1, 8), $urandom_range(1, 8), 255, 0);
        repeat (520) send_tick(next_levels(0, 0));
      end else begin
        set_scan($urandom_range(9) != 0,
                 ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
                 ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
                 ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(1, 6),
                 $urandom_range(0, 4));
        repeat (180) send_tick(next_levels(3, noise));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_SCAN_ENABLE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    col_levels  = '0;
    out_stall   = 1'b0;
    held_levels = '1;
    reset_scan_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_disabled();
    test_full_rows();
    test_filter_zero();
    test_count_clamp();
    test_bounce();
    test_random_scan();
    test_interval_max();
    drain_beats();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_key_matrix_scan_debounce: done, clean");
    end else begin
      $display("tb_key_matrix_scan_debounce: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kmsd_pkg.sv
design/kmsd_seq.sv
design/kmsd_lane.sv
design/kmsd_merge.sv
design/key_matrix_scan_debounce.sv
verif/tb_key_matrix_scan_debounce.sv
